FILE: hdl/kvft_pkg.sv
// ----------------------------------------------------------------------------
// kvft_pkg
// Types and constants shared by the keyed visit flag table and its cells.
// ----------------------------------------------------------------------------
package kvft_pkg;

    localparam int KEY_W      = 24;
    localparam int SLOT_W     = 6;
    localparam int SLOT_IDX_W = 8;   // wide enough for the largest table
    localparam int FLAG_IDX_W = 9;   // wide enough for the largest bitmap

    localparam logic [KEY_W-1:0] EMPTY_KEY = 24'hff_ffff;

    localparam logic KIND_MARK  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] key_x;
        logic [7:0] key_y;
        logic [7:0] key_z;
        logic [7:0] bit_index;
    } kvft_in_t;

    typedef struct packed {
        logic              flag_set;
        logic              key_found;
        logic              table_full;
        logic [SLOT_W-1:0] slot;
    } kvft_out_t;

    // Request broadcast to every cell while an item is in flight.
    typedef struct packed {
        logic                  kind;
        logic [KEY_W-1:0]      key;
        logic                  bit_ok;
        logic [FLAG_IDX_W-1:0] bit_idx;
    } kvft_req_t;

    // Priority chain handed from cell to cell, lowest slot first.
    typedef struct packed {
        logic                  hit;
        logic                  empty;
        logic [SLOT_IDX_W-1:0] hit_slot;
        logic                  hit_flag;
        logic [SLOT_IDX_W-1:0] empty_slot;
    } kvft_chain_t;

endpackage

FILE: hdl/keyed_visit_flag_table.sv
// ----------------------------------------------------------------------------
// keyed_visit_flag_table
// Associative table of 24-bit coordinate keys, each with a flag bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one item per transfer: kind (mark or query), a three-byte
//   key and a flag bit index. m_ channel returns exactly one result per item:
//   flag_set, key_found, table_full and the slot matched or claimed.
//   Each item passes a compare state and then an update state, and its
//   result is registered on m_data at the end of the update. The compare
//   state registers the key compare in every cell; the update state resolves
//   the lowest match or empty slot along the cell chain and, for a mark,
//   updates that cell's key and flags. The next item may transfer in the
//   update state, so its compare sees the table as left by the item before it.
//   When the receiver stalls, the result holds in the output register and
//   the block holds its update, taking no new item until the result can go.
//   Reset (aresetn low, synchronous) empties every key to 0xffffff, clears
//   all flags and drops any pending result.
// ----------------------------------------------------------------------------
module keyed_visit_flag_table import kvft_pkg::*; #(
    parameter int ENTRIES   = 40,
    parameter int FLAG_BITS = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  kvft_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output kvft_out_t m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;
    kvft_req_t  req_reg;
    logic       m_valid_reg, m_valid_next;
    kvft_out_t  m_data_reg, m_data_next;

    logic        s_xfer;
    logic        out_free;
    logic        upd_go;
    kvft_chain_t chain [ENTRIES+1];
    kvft_chain_t tail;

    assign out_free = ~m_valid_reg | m_ready;
    assign upd_go   = (state_reg == ST_UPD) && out_free;
    assign s_ready  = (state_reg == ST_IDLE) || upd_go;
    assign s_xfer   = s_valid & s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Cell row: chain head carries nothing, tail gives the resolved slot.
    assign chain[0] = '0;
    assign tail     = chain[ENTRIES];

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        kvft_cell #(
            .IDX       (i),
            .FLAG_BITS (FLAG_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .req       (req_reg),
            .cmp_en    (state_reg == ST_CMP),
            .upd_en    (upd_go),
            .any_hit   (tail.hit),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    // Next state and result assembly.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (upd_go) begin
                    state_next   = s_xfer ? ST_CMP : ST_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next.key_found = tail.hit;
                    if (req_reg.kind == KIND_QUERY) begin
                        m_data_next.flag_set = tail.hit & tail.hit_flag;
                        m_data_next.slot     = tail.hit ? SLOT_W'(tail.hit_slot) : '0;
                    end else if (tail.hit) begin
                        m_data_next.slot = SLOT_W'(tail.hit_slot);
                    end else if (tail.empty) begin
                        m_data_next.slot = SLOT_W'(tail.empty_slot);
                    end else begin
                        m_data_next.table_full = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the request at its transfer; hold it through compare and update.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_xfer) begin
            req_reg.kind    <= s_data.kind;
            req_reg.key     <= {s_data.key_x, s_data.key_y, s_data.key_z};
            req_reg.bit_ok  <= (32'(s_data.bit_index) < FLAG_BITS);
            req_reg.bit_idx <= FLAG_IDX_W'(s_data.bit_index);
        end
    end

`ifndef SYNTHESIS
    a_no_accept_in_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> !s_ready)
        else $error("input accepted during compare cycle");

    a_accept_to_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CMP))
        else $error("accepted item did not enter compare");

    a_update_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_UPD) && out_free) |=> m_valid)
        else $error("update cycle produced no result");

    a_full_excludes_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.table_full && (m_data.key_found || m_data.slot != '0)))
        else $error("table_full result with a slot or a match");
`endif

endmodule

FILE: hdl/kvft_cell.sv
// ----------------------------------------------------------------------------
// kvft_cell
// One table slot: key, flag bitmap, registered compare and chain stage.
// ----------------------------------------------------------------------------
module kvft_cell import kvft_pkg::*; #(
    parameter int IDX       = 0,
    parameter int FLAG_BITS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  kvft_req_t   req,
    input  logic        cmp_en,
    input  logic        upd_en,
    input  logic        any_hit,
    input  kvft_chain_t chain_in,
    output kvft_chain_t chain_out
);

    localparam int BW = $clog2(FLAG_BITS);

    logic [KEY_W-1:0]     key_reg;
    logic [FLAG_BITS-1:0] flags_reg;
    logic                 match_reg;
    logic                 empty_reg;

    logic          sel_hit;
    logic          sel_empty;
    logic          target;
    logic          flag_bit;
    logic [BW-1:0] idx;

    assign idx       = req.bit_idx[BW-1:0];
    assign sel_hit   = match_reg & ~chain_in.hit;
    assign sel_empty = empty_reg & ~chain_in.empty;
    assign target    = any_hit ? sel_hit : sel_empty;
    assign flag_bit  = req.bit_ok & flags_reg[idx];

    always_comb begin
        chain_out.hit        = chain_in.hit | match_reg;
        chain_out.empty      = chain_in.empty | empty_reg;
        chain_out.hit_slot   = chain_in.hit_slot |
                               (sel_hit ? SLOT_IDX_W'(IDX) : '0);
        chain_out.hit_flag   = chain_in.hit_flag | (sel_hit & flag_bit);
        chain_out.empty_slot = chain_in.empty_slot |
                               (sel_empty ? SLOT_IDX_W'(IDX) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= EMPTY_KEY;
            flags_reg <= '0;
            match_reg <= 1'b0;
            empty_reg <= 1'b0;
        end else begin
            if (cmp_en) begin
                match_reg <= (key_reg == req.key);
                empty_reg <= (key_reg == EMPTY_KEY);
            end
            if (upd_en && req.kind == KIND_MARK && target) begin
                // claim: write the key only when no slot already matched
                if (!any_hit) begin
                    key_reg <= req.key;
                end
                if (req.bit_ok) begin
                    flags_reg[idx] <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: tb/tb_keyed_visit_flag_table.sv
// ----------------------------------------------------------------------------
// tb_keyed_visit_flag_table
// Self-checking bench for the keyed visit flag table.
// Items are queued by a stimulus process and offered by a clocked driver. A
// clocked monitor predicts each result from its own copy of the key table and
// flag bitmaps and checks every returned result in order. Both handshake
// sides idle in random bursts, the receiver holds off once for a long
// stretch, and the table is driven from sparse use through to full.
// ----------------------------------------------------------------------------
module tb_keyed_visit_flag_table;
    timeunit 1ns;
    timeprecision 1ps;

    import kvft_pkg::*;

    localparam int TBL_ENTRIES = 40;
    localparam int TBL_FLAGS   = 256;
    localparam int POOL_KEYS   = 24;
    localparam int LONG_HOLD   = 100;   // receiver hold-off, in cycles
    localparam int STALL_LIMIT = 2000;  // cycles without any transfer
    localparam int DRAIN_WAIT  = 8;     // settle time after the last result
    localparam int QUIET_TAIL  = 150;   // items left when idling stops
    localparam int MAX_REPORTS = 10;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    kvft_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    kvft_out_t m_data;

    // Shadow of the table: one key and one flag bitmap per slot.
    logic [KEY_W-1:0]     coord_keys  [TBL_ENTRIES];
    logic [TBL_FLAGS-1:0] visit_flags [TBL_ENTRIES];
    logic [KEY_W-1:0]     key_pool    [POOL_KEYS];

    kvft_in_t  pending_visits[$];   // items not yet offered
    kvft_out_t visit_answers[$];    // predicted results, oldest first

    logic in_taken    = 1'b0;       // input transfer seen at the last edge
    logic tail_quiet  = 1'b0;       // no idling from here on
    int   holds_asked = 0;
    int   holds_served = 0;
    int   hold_left   = 0;
    int   send_gap    = 0;
    int   sink_gap    = 0;
    int   fail_count  = 0;
    int   results_seen = 0;
    int   idle_cycles = 0;

    keyed_visit_flag_table #(
        .ENTRIES   (TBL_ENTRIES),
        .FLAG_BITS (TBL_FLAGS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Lowest slot holding the key, or -1. The empty key matches empty slots.
    function automatic int lowest_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < TBL_ENTRIES; i++) begin
            if (coord_keys[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Apply one item to the shadow table and return the result it yields.
    function automatic kvft_out_t apply_visit(input kvft_in_t item);
        logic [KEY_W-1:0] key;
        int               hit;
        int               target;
        kvft_out_t        res;
        key    = {item.key_x, item.key_y, item.key_z};
        res    = '0;
        hit    = lowest_slot(key);
        target = hit;
        if (item.kind == KIND_MARK) begin
            if (hit >= 0) begin
                res.key_found = 1'b1;
            end else begin
                // Claim the lowest empty slot; its old flags stay as they are.
                target = lowest_slot(EMPTY_KEY);
                if (target >= 0)
                    coord_keys[target] = key;
            end
            if (target >= 0) begin
                res.slot = SLOT_W'(target);
                if (item.bit_index < TBL_FLAGS)
                    visit_flags[target][item.bit_index] = 1'b1;
            end else begin
                res.table_full = 1'b1;
            end
        end else if (hit >= 0) begin
            res.key_found = 1'b1;
            res.slot      = SLOT_W'(hit);
            res.flag_set  = (item.bit_index < TBL_FLAGS) &&
                            visit_flags[hit][item.bit_index];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_visit(input logic kind, input logic [7:0] kx,
                               input logic [7:0] ky, input logic [7:0] kz,
                               input logic [7:0] bit_ix);
        kvft_in_t item;
        item.kind      = kind;
        item.key_x     = kx;
        item.key_y     = ky;
        item.key_z     = kz;
        item.bit_index = bit_ix;
        pending_visits.push_back(item);
    endtask

    // Mostly known keys so flags pile up; some empty keys and fresh keys.
    function automatic logic [KEY_W-1:0] pick_key(input int fresh_pct,
                                                  input int empty_pct);
        int roll;
        logic [31:0] raw;
        roll = $urandom_range(0, 99);
        raw  = $urandom;
        if (roll < empty_pct)
            return EMPTY_KEY;
        if (roll < empty_pct + fresh_pct)
            return raw[KEY_W-1:0];
        return key_pool[$urandom_range(0, POOL_KEYS - 1)];
    endfunction

    // Favor low bit indexes so queries find set bits often.
    function automatic logic [7:0] pick_bit();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 8'd0;
        if (roll == 1)
            return 8'd255;
        if (roll < 5)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 15));
    endfunction

    task automatic random_visits(input int count, input int fresh_pct,
                                 input int empty_pct, input int mark_pct);
        logic [KEY_W-1:0] key;
        logic             kind;
        for (int n = 0; n < count; n++) begin
            key  = pick_key(fresh_pct, empty_pct);
            kind = ($urandom_range(0, 99) < mark_pct) ? KIND_MARK : KIND_QUERY;
            queue_visit(kind, key[23:16], key[15:8], key[7:0], pick_bit());
        end
    endtask

    // Hold until nothing is queued, offered or outstanding.
    task automatic wait_drained();
        while (pending_visits.size() != 0 || s_valid || visit_answers.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the next queued item once the current one has transferred.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : p_drive
        logic     next_valid;
        kvft_in_t next_data;
        next_valid = s_valid;
        next_data  = s_data;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else if (!s_valid || in_taken) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (!tail_quiet && $urandom_range(0, 11) == 0) begin
                // Idle this cycle and the rest of the burst.
                send_gap = $urandom_range(1, 15) - 1;
            end else if (pending_visits.size() != 0) begin
                next_data  = pending_visits.pop_front();
                next_valid = 1'b1;
            end
        end
        s_valid <= next_valid;
        s_data  <= next_data;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus the long hold-off when asked.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : p_sink
        logic ready_next;
        if (!aresetn) begin
            ready_next = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left  = LONG_HOLD - 1;
            ready_next = 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            ready_next = 1'b0;
        end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
            sink_gap   = $urandom_range(1, 15) - 1;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
        end
        m_ready <= ready_next;
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result against the oldest prediction, then predict
    // for the item transferred at this edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : p_check
        kvft_out_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                results_seen++;
                if (visit_answers.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("result %0d arrived with none pending", results_seen);
                        $display("  got  flag_set=%0b key_found=%0b table_full=%0b slot=%0d",
                                 m_data.flag_set, m_data.key_found,
                                 m_data.table_full, m_data.slot);
                    end
                end else begin
                    want = visit_answers.pop_front();
                    if (m_data.flag_set !== want.flag_set ||
                        m_data.key_found !== want.key_found ||
                        m_data.table_full !== want.table_full ||
                        m_data.slot !== want.slot) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("result %0d mismatch", results_seen);
                            $display("  want flag_set=%0b key_found=%0b table_full=%0b slot=%0d",
                                     want.flag_set, want.key_found,
                                     want.table_full, want.slot);
                            $display("  got  flag_set=%0b key_found=%0b table_full=%0b slot=%0d",
                                     m_data.flag_set, m_data.key_found,
                                     m_data.table_full, m_data.slot);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                visit_answers.push_back(apply_visit(s_data));
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no transfer happens for too long.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : p_watchdog
        if (aresetn && !(s_valid && s_ready) && !(m_valid && m_ready))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] raw;
        for (int i = 0; i < TBL_ENTRIES; i++) begin
            coord_keys[i]  = EMPTY_KEY;
            visit_flags[i] = '0;
        end
        for (int i = 0; i < POOL_KEYS; i++) begin
            raw         = $urandom;
            key_pool[i] = raw[KEY_W-1:0];
            if (key_pool[i] == EMPTY_KEY)
                key_pool[i] = 24'h000001;
        end

        // Directed: empty table, the empty key as an ordinary key, a claim
        // that inherits flags left by an empty-key mark, hits and misses.
        queue_visit(KIND_QUERY, 8'h00, 8'h00, 8'h00, 8'd0);
        queue_visit(KIND_QUERY, 8'hff, 8'hff, 8'hff, 8'd0);
        queue_visit(KIND_MARK,  8'hff, 8'hff, 8'hff, 8'd255);
        queue_visit(KIND_QUERY, 8'hff, 8'hff, 8'hff, 8'd255);
        queue_visit(KIND_MARK,  8'h00, 8'h00, 8'h00, 8'd0);
        queue_visit(KIND_QUERY, 8'h00, 8'h00, 8'h00, 8'd255);
        queue_visit(KIND_QUERY, 8'h00, 8'h00, 8'h00, 8'd0);
        queue_visit(KIND_MARK,  8'h01, 8'h02, 8'h03, 8'd7);
        queue_visit(KIND_MARK,  8'h01, 8'h02, 8'h03, 8'd8);
        queue_visit(KIND_QUERY, 8'h01, 8'h02, 8'h03, 8'd7);
        queue_visit(KIND_QUERY, 8'h01, 8'h02, 8'h03, 8'd9);
        queue_visit(KIND_MARK,  8'hff, 8'h00, 8'hff, 8'd128);
        queue_visit(KIND_QUERY, 8'hff, 8'h00, 8'hff, 8'd128);
        queue_visit(KIND_QUERY, 8'h00, 8'hff, 8'hff, 8'd128);
        queue_visit(KIND_MARK,  8'h80, 8'h7f, 8'h55, 8'haa);
        queue_visit(KIND_QUERY, 8'h80, 8'h7f, 8'h55, 8'haa);
        queue_visit(KIND_QUERY, 8'h80, 8'h7f, 8'h55, 8'h55);
        queue_visit(KIND_MARK,  8'h7f, 8'h80, 8'haa, 8'h55);
        queue_visit(KIND_QUERY, 8'hff, 8'hff, 8'hff, 8'd0);
        queue_visit(KIND_MARK,  8'h00, 8'hff, 8'h00, 8'd1);
        queue_visit(KIND_QUERY, 8'h00, 8'hff, 8'h00, 8'd254);

        // Hold reset, then release it on a falling edge.
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Pause the sender until every directed result is back.
        wait_drained();

        // Keep offering while the receiver holds off: the block fills up and
        // must stall its input.
        random_visits(40, 0, 10, 50);
        holds_asked = holds_asked + 1;

        // Mostly known keys, a few fresh claims, empty-key marks in between.
        random_visits(1000, 1, 10, 50);
        wait_drained();

        // Fill the table with fresh marks, then run on with it full.
        random_visits(60, 100, 0, 100);
        random_visits(780, 15, 10, 50);

        // Drop all idling for the last stretch.
        while (pending_visits.size() > QUIET_TAIL)
            @(posedge aclk);
        tail_quiet = 1'b1;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (visit_answers.size() != 0) begin
            fail_count++;
            $display("%0d predicted results never arrived", visit_answers.size());
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
